>>> rtl/core/rae_pkg.sv
// Shared types and constants for the register ALU execute block.
package rae_pkg;

    localparam int unsigned XLEN     = 32;
    localparam int unsigned REG_CNT  = 16;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned FLAG_W   = 4;

    // Flag bit positions inside the NZCV nibble
    localparam int unsigned FLAG_N = 3;
    localparam int unsigned FLAG_Z = 2;
    localparam int unsigned FLAG_C = 1;
    localparam int unsigned FLAG_V = 0;

    typedef enum logic [4:0] {
        OP_ADCS  = 5'd0,
        OP_ADD   = 5'd1,
        OP_ADDS  = 5'd2,
        OP_RSBS  = 5'd3,
        OP_SBCS  = 5'd4,
        OP_SUB   = 5'd5,
        OP_SUBS  = 5'd6,
        OP_ANDS  = 5'd7,
        OP_ORRS  = 5'd8,
        OP_EORS  = 5'd9,
        OP_BICS  = 5'd10,
        OP_ASRS  = 5'd11,
        OP_LSLS  = 5'd12,
        OP_LSRS  = 5'd13,
        OP_RORS  = 5'd14,
        OP_CMP   = 5'd15,
        OP_CMN   = 5'd16,
        OP_MOV   = 5'd17,
        OP_MOVS  = 5'd18,
        OP_MVNS  = 5'd19,
        OP_MULS  = 5'd20,
        OP_REV   = 5'd21,
        OP_REV16 = 5'd22,
        OP_REVSH = 5'd23,
        OP_SXTB  = 5'd24,
        OP_SXTH  = 5'd25,
        OP_UXTB  = 5'd26,
        OP_UXTH  = 5'd27,
        OP_TST   = 5'd28,
        OP_CPSID = 5'd29,
        OP_CPSIE = 5'd30,
        OP_NOP   = 5'd31
    } t_op;

    // Register file write port
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

    // What one operation produces
    typedef struct packed {
        logic [XLEN-1:0]   value;
        logic              write;
        logic [FLAG_W-1:0] flags;
        logic              mask;
    } t_alu_res;

endpackage

>>> rtl/core/rae_regfile.sv
// Register file with reset-valid bits, registered reads and write bypass.
module rae_regfile (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [rae_pkg::IDX_W-1:0]     i_rd_a_idx,
    input  logic [rae_pkg::IDX_W-1:0]     i_rd_b_idx,
    input  rae_pkg::t_rf_wr               i_wr,
    output logic [rae_pkg::XLEN-1:0]      o_a,
    output logic [rae_pkg::XLEN-1:0]      o_b
);

    logic [rae_pkg::XLEN-1:0]    mem [rae_pkg::REG_CNT];
    logic [rae_pkg::REG_CNT-1:0] r_vld;

    logic [rae_pkg::XLEN-1:0]    r_a_mem;
    logic [rae_pkg::XLEN-1:0]    r_b_mem;
    logic                        r_a_vld;
    logic                        r_b_vld;
    logic                        r_a_fwd;
    logic                        r_b_fwd;
    logic [rae_pkg::XLEN-1:0]    r_fwd_val;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_a_mem <= mem[i_rd_a_idx];
            r_b_mem <= mem[i_rd_b_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_a_fwd <= 1'b0;
            r_b_fwd <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_a_vld <= r_vld[i_rd_a_idx];
                r_b_vld <= r_vld[i_rd_b_idx];
                // memory returns old data on a same-edge write: catch it here
                r_a_fwd <= i_wr.en && (i_wr.idx == i_rd_a_idx);
                r_b_fwd <= i_wr.en && (i_wr.idx == i_rd_b_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_fwd_val <= i_wr.data;
        end
    end

    assign o_a = r_a_fwd ? r_fwd_val : (r_a_vld ? r_a_mem : '0);
    assign o_b = r_b_fwd ? r_fwd_val : (r_b_vld ? r_b_mem : '0);

endmodule

>>> rtl/core/rae_alu.sv
// Data-processing datapath: adder, shifter, logic, multiply, byte ops and flags.
module rae_alu (
    input  rae_pkg::t_op                   i_op,
    input  logic [rae_pkg::XLEN-1:0]       i_a,
    input  logic [rae_pkg::XLEN-1:0]       i_b,
    input  logic [rae_pkg::FLAG_W-1:0]     i_flags,
    input  logic                           i_mask,
    output rae_pkg::t_alu_res              o_res
);

    localparam int unsigned XLEN = rae_pkg::XLEN;

    logic [XLEN-1:0]   add_x;
    logic [XLEN-1:0]   add_y;
    logic              add_cin;
    logic [XLEN:0]     sum;
    logic [XLEN-1:0]   add_r;
    logic [3:0]        add_f;

    logic              c_old;
    logic              v_old;
    logic [7:0]        sh_n;
    logic [4:0]        sh_s;
    logic [4:0]        sh_s_m1;
    logic [4:0]        sh_s_neg;
    logic              sh_zero;
    logic              sh_small;
    logic              sh_32;

    logic [XLEN-1:0]   asr_r;
    logic              asr_c;
    logic [XLEN-1:0]   lsl_r;
    logic              lsl_c;
    logic [XLEN-1:0]   lsr_r;
    logic              lsr_c;
    logic [XLEN-1:0]   ror_r;
    logic              ror_c;
    logic [XLEN-1:0]   mul_r;
    logic [XLEN-1:0]   val;

    assign c_old = i_flags[rae_pkg::FLAG_C];
    assign v_old = i_flags[rae_pkg::FLAG_V];

    // One shared adder; subtracts feed the inverted operand with carry in
    always_comb begin
        add_x   = i_a;
        add_y   = i_b;
        add_cin = 1'b0;
        case (i_op) inside
            rae_pkg::OP_ADCS: begin
                add_cin = c_old;
            end
            rae_pkg::OP_RSBS: begin
                add_x   = '0;
                add_y   = ~i_a;
                add_cin = 1'b1;
            end
            rae_pkg::OP_SBCS: begin
                add_y   = ~i_b;
                add_cin = c_old;
            end
            rae_pkg::OP_SUB, rae_pkg::OP_SUBS, rae_pkg::OP_CMP: begin
                add_y   = ~i_b;
                add_cin = 1'b1;
            end
            default: begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign sum   = {1'b0, add_x} + {1'b0, add_y} + {{XLEN{1'b0}}, add_cin};
    assign add_r = sum[XLEN-1:0];
    assign add_f = {add_r[XLEN-1], add_r == '0, sum[XLEN],
                    ((add_x ^ add_r) & (add_y ^ add_r)) >> (XLEN - 1) != '0};

    assign sh_n     = i_b[7:0];
    assign sh_s     = i_b[4:0];
    assign sh_s_m1  = sh_s - 5'd1;
    assign sh_s_neg = 5'd0 - sh_s;
    assign sh_zero  = (sh_n == 8'd0);
    assign sh_small = (sh_n[7:5] == 3'd0);
    assign sh_32    = (sh_n == 8'd32);

    always_comb begin
        if (sh_zero) begin
            asr_r = i_a;
            asr_c = c_old;
            lsl_r = i_a;
            lsl_c = c_old;
            lsr_r = i_a;
            lsr_c = c_old;
        end else if (sh_small) begin
            asr_r = XLEN'($signed(i_a) >>> sh_s);
            asr_c = i_a[sh_s_m1];
            lsl_r = i_a << sh_s;
            lsl_c = i_a[sh_s_neg];
            lsr_r = i_a >> sh_s;
            lsr_c = i_a[sh_s_m1];
        end else begin
            asr_r = {XLEN{i_a[XLEN-1]}};
            asr_c = i_a[XLEN-1];
            lsl_r = '0;
            lsl_c = sh_32 ? i_a[0] : 1'b0;
            lsr_r = '0;
            lsr_c = sh_32 ? i_a[XLEN-1] : 1'b0;
        end
    end

    // Rotate by the low five bits; a nonzero multiple of 32 leaves A as is
    always_comb begin
        ror_r = XLEN'({i_a, i_a} >> sh_s);
        ror_c = sh_zero ? c_old : ror_r[XLEN-1];
    end

    assign mul_r = XLEN'(i_a * i_b);

    always_comb begin
        val         = '0;
        o_res.write = 1'b1;
        o_res.flags = i_flags;
        o_res.mask  = i_mask;
        unique case (i_op) inside
            rae_pkg::OP_ADCS, rae_pkg::OP_ADDS, rae_pkg::OP_RSBS,
            rae_pkg::OP_SBCS, rae_pkg::OP_SUBS: begin
                val         = add_r;
                o_res.flags = add_f;
            end
            rae_pkg::OP_CMP, rae_pkg::OP_CMN: begin
                val         = add_r;
                o_res.flags = add_f;
                o_res.write = 1'b0;
            end
            rae_pkg::OP_ADD, rae_pkg::OP_SUB: begin
                val = add_r;
            end
            rae_pkg::OP_ANDS: begin
                val         = i_a & i_b;
                o_res.flags = {val[XLEN-1], val == '0, c_old, v_old};
            end
            rae_pkg::OP_TST: begin
                val         = i_a & i_b;
                o_res.flags = {val[XLEN-1], val == '0, c_old, v_old};
                o_res.write = 1'b0;
            end
            rae_pkg::OP_ORRS: begin
                val         = i_a | i_b;
                o_res.flags = {val[XLEN-1], val == '0, c_old, v_old};
            end
            rae_pkg::OP_EORS: begin
                val         = i_a ^ i_b;
                o_res.flags = {val[XLEN-1], val == '0, c_old, v_old};
            end
            rae_pkg::OP_BICS: begin
                val         = i_a & ~i_b;
                o_res.flags = {val[XLEN-1], val == '0, c_old, v_old};
            end
            rae_pkg::OP_ASRS: begin
                val         = asr_r;
                o_res.flags = {val[XLEN-1], val == '0, asr_c, v_old};
            end
            rae_pkg::OP_LSLS: begin
                val         = lsl_r;
                o_res.flags = {val[XLEN-1], val == '0, lsl_c, v_old};
            end
            rae_pkg::OP_LSRS: begin
                val         = lsr_r;
                o_res.flags = {val[XLEN-1], val == '0, lsr_c, v_old};
            end
            rae_pkg::OP_RORS: begin
                val         = ror_r;
                o_res.flags = {val[XLEN-1], val == '0, ror_c, v_old};
            end
            rae_pkg::OP_MOV: begin
                val = i_b;
            end
            rae_pkg::OP_MOVS: begin
                val         = i_b;
                o_res.flags = {val[XLEN-1], val == '0, c_old, v_old};
            end
            rae_pkg::OP_MVNS: begin
                val         = ~i_b;
                o_res.flags = {val[XLEN-1], val == '0, c_old, v_old};
            end
            rae_pkg::OP_MULS: begin
                val         = mul_r;
                o_res.flags = {val[XLEN-1], val == '0, c_old, v_old};
            end
            rae_pkg::OP_REV: begin
                val = {i_b[7:0], i_b[15:8], i_b[23:16], i_b[31:24]};
            end
            rae_pkg::OP_REV16: begin
                val = {i_b[23:16], i_b[31:24], i_b[7:0], i_b[15:8]};
            end
            rae_pkg::OP_REVSH: begin
                val = {{16{i_b[7]}}, i_b[7:0], i_b[15:8]};
            end
            rae_pkg::OP_SXTB: begin
                val = {{24{i_b[7]}}, i_b[7:0]};
            end
            rae_pkg::OP_SXTH: begin
                val = {{16{i_b[15]}}, i_b[15:0]};
            end
            rae_pkg::OP_UXTB: begin
                val = {24'd0, i_b[7:0]};
            end
            rae_pkg::OP_UXTH: begin
                val = {16'd0, i_b[15:0]};
            end
            rae_pkg::OP_CPSID: begin
                o_res.write = 1'b0;
                o_res.mask  = 1'b1;
            end
            rae_pkg::OP_CPSIE: begin
                o_res.write = 1'b0;
                o_res.mask  = 1'b0;
            end
            default: begin
                o_res.write = 1'b0;
            end
        endcase
        o_res.value = val;
    end

endmodule

>>> rtl/core/register_alu_execute_nzcv.sv
// Top level of the register ALU execute block with NZCV flags.
//
// Input channel: i_in_valid / o_in_stall carry one decoded data-processing
// operation per beat (mode, register numbers, immediate select, immediate).
// Output channel: o_out_valid / i_out_stall carry one result beat per input
// beat: value, register written, write flag, NZCV and interrupt mask after
// the operation.
// On the way from input beat to result beat, the operand stage reads the
// register file (registered read, with bypass of the write in flight),
// then the execute stage runs the ALU, writes back and loads the result.
// Throughput is one beat per cycle while the receiver does not stall; a
// dependent operation may follow in the very next cycle. The 32x32
// multiplier sits in the execute stage.
// Reset clears the pipeline, the flags, the interrupt mask and all sixteen
// registers (through per-register valid bits, so no clearing pass).
// While the receiver stalls, the result beat holds; the operand stage keeps
// its beat and o_in_stall rises once it is full.
module register_alu_execute_nzcv (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [4:0]                     i_mode,
    input  logic [rae_pkg::IDX_W-1:0]      i_dest_index,
    input  logic [rae_pkg::IDX_W-1:0]      i_first_index,
    input  logic [rae_pkg::IDX_W-1:0]      i_second_index,
    input  logic                           i_use_immediate,
    input  logic [rae_pkg::XLEN-1:0]       i_immediate,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [rae_pkg::XLEN-1:0]       o_result_value,
    output logic [rae_pkg::IDX_W-1:0]      o_written_index,
    output logic                           o_write_done,
    output logic [rae_pkg::FLAG_W-1:0]     o_flags_nzcv,
    output logic                           o_interrupts_masked
);

    logic                           in_accept;
    logic                           out_ready;
    logic                           s1_fire;

    logic                           r_s1_valid;
    rae_pkg::t_op                   r_s1_op;
    logic [rae_pkg::IDX_W-1:0]      r_s1_dest;
    logic                           r_s1_use_imm;
    logic [rae_pkg::XLEN-1:0]       r_s1_imm;

    logic [rae_pkg::XLEN-1:0]       rf_a;
    logic [rae_pkg::XLEN-1:0]       rf_b;
    logic [rae_pkg::XLEN-1:0]       opnd_b;
    rae_pkg::t_rf_wr                rf_wr;
    rae_pkg::t_alu_res              alu_res;

    logic [rae_pkg::FLAG_W-1:0]     r_flags;
    logic                           r_mask;

    logic                           r_out_valid;
    logic [rae_pkg::XLEN-1:0]       r_out_value;
    logic [rae_pkg::IDX_W-1:0]      r_out_index;
    logic                           r_out_write;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && out_ready;
    assign o_in_stall = r_s1_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign rf_wr.en   = s1_fire && alu_res.write;
    assign rf_wr.idx  = r_s1_dest;
    assign rf_wr.data = alu_res.value;

    rae_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_accept),
        .i_rd_a_idx (i_first_index),
        .i_rd_b_idx (i_second_index),
        .i_wr       (rf_wr),
        .o_a        (rf_a),
        .o_b        (rf_b)
    );

    assign opnd_b = r_s1_use_imm ? r_s1_imm : rf_b;

    rae_alu u_alu (
        .i_op    (r_s1_op),
        .i_a     (rf_a),
        .i_b     (opnd_b),
        .i_flags (r_flags),
        .i_mask  (r_mask),
        .o_res   (alu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_mask      <= 1'b0;
        end else begin
            if (in_accept || s1_fire) begin
                r_s1_valid <= in_accept;
            end
            if (out_ready) begin
                r_out_valid <= s1_fire;
            end
            if (s1_fire) begin
                r_flags <= alu_res.flags;
                r_mask  <= alu_res.mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op      <= rae_pkg::t_op'(i_mode);
            r_s1_dest    <= i_dest_index;
            r_s1_use_imm <= i_use_immediate;
            r_s1_imm     <= i_immediate;
        end
        if (s1_fire) begin
            r_out_value <= alu_res.value;
            r_out_index <= alu_res.write ? r_s1_dest : '0;
            r_out_write <= alu_res.write;
        end
    end

    // Flags and mask only advance together with the result register
    assign o_out_valid         = r_out_valid;
    assign o_result_value      = r_out_value;
    assign o_written_index     = r_out_index;
    assign o_write_done        = r_out_write;
    assign o_flags_nzcv        = r_flags;
    assign o_interrupts_masked = r_mask;

endmodule

>>> rtl/core/rae_checker.sv
// Port-level checks for the register ALU execute block, bound to the top level.
module rae_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic [rae_pkg::XLEN-1:0]       o_result_value,
    input  logic [rae_pkg::IDX_W-1:0]      o_written_index,
    input  logic                           o_write_done,
    input  logic [rae_pkg::FLAG_W-1:0]     o_flags_nzcv,
    input  logic                           o_interrupts_masked
);

    // A stalled result beat holds, flags and mask included
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_written_index) && $stable(o_write_done)
            && $stable(o_flags_nzcv) && $stable(o_interrupts_masked))
        else $error("result beat changed while stalled");

    a_no_write_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_write_done |-> o_written_index == '0)
        else $error("written index nonzero without a register write");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // An accepted beat reaches the output through the operand and result registers when the receiver takes beats
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted beat did not reach the output in two cycles");

endmodule

bind register_alu_execute_nzcv rae_checker u_rae_checker (.*);

>>> sim/register_alu_execute_nzcv_checker.sv
// Result checker for register_alu_execute_nzcv: tracks registers and flags, compares beats.
module register_alu_execute_nzcv_checker
    import rae_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [4:0]          i_mode,
    input  logic [IDX_W-1:0]    i_dest_index,
    input  logic [IDX_W-1:0]    i_first_index,
    input  logic [IDX_W-1:0]    i_second_index,
    input  logic                i_use_immediate,
    input  logic [XLEN-1:0]     i_immediate,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [XLEN-1:0]     i_result_value,
    input  logic [IDX_W-1:0]    i_written_index,
    input  logic                i_write_done,
    input  logic [FLAG_W-1:0]   i_flags_nzcv,
    input  logic                i_interrupts_masked,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [XLEN-1:0]   value;
        logic [IDX_W-1:0]  idx;
        logic              wr;
        logic [FLAG_W-1:0] nzcv;
        logic              mask;
    } t_exec_result;

    logic [XLEN-1:0]   arch_regs [REG_CNT];
    logic [FLAG_W-1:0] arch_flags;
    logic              arch_mask;
    t_exec_result      due_results [$];
    int                fail_cnt;

    function automatic logic [1:0] nz_bits(input logic [XLEN-1:0] r);
        return {r[XLEN-1], r == '0};
    endfunction

    task automatic add_with_flags(input logic [XLEN-1:0] a, input logic [XLEN-1:0] b,
                                  input logic cin, output logic [XLEN-1:0] r,
                                  output logic [FLAG_W-1:0] f);
        logic [XLEN:0] sum;
        sum = {1'b0, a} + {1'b0, b} + {{XLEN{1'b0}}, cin};
        r   = sum[XLEN-1:0];
        f   = {nz_bits(r), sum[XLEN], (a[XLEN-1] ^ r[XLEN-1]) & (b[XLEN-1] ^ r[XLEN-1])};
    endtask

    // Execute one operation on the tracked state and queue what the block must report.
    task automatic execute_op(input t_op op, input logic [IDX_W-1:0] rd,
                              input logic [IDX_W-1:0] rn, input logic [IDX_W-1:0] rm,
                              input logic use_imm, input logic [XLEN-1:0] imm);
        logic [XLEN-1:0]   a, b, r;
        logic [FLAG_W-1:0] f;
        logic [7:0]        n;
        logic [4:0]        s;
        logic              c, wr, setf, nz_only, shift_op;
        t_exec_result      res;
        a        = arch_regs[rn];
        b        = use_imm ? imm : arch_regs[rm];
        n        = b[7:0];
        c        = arch_flags[FLAG_C];
        r        = '0;
        f        = arch_flags;
        wr       = 1'b1;
        setf     = 1'b1;
        nz_only  = 1'b0;
        shift_op = 1'b0;
        case (op)
            OP_ADCS:  add_with_flags(a, b, arch_flags[FLAG_C], r, f);
            OP_ADD: begin
                r    = a + b;
                setf = 1'b0;
            end
            OP_ADDS:  add_with_flags(a, b, 1'b0, r, f);
            OP_RSBS:  add_with_flags('0, ~a, 1'b1, r, f);
            OP_SBCS:  add_with_flags(a, ~b, arch_flags[FLAG_C], r, f);
            OP_SUB: begin
                r    = a - b;
                setf = 1'b0;
            end
            OP_SUBS:  add_with_flags(a, ~b, 1'b1, r, f);
            OP_ANDS: begin
                r       = a & b;
                nz_only = 1'b1;
            end
            OP_ORRS: begin
                r       = a | b;
                nz_only = 1'b1;
            end
            OP_EORS: begin
                r       = a ^ b;
                nz_only = 1'b1;
            end
            OP_BICS: begin
                r       = a & ~b;
                nz_only = 1'b1;
            end
            OP_ASRS: begin
                shift_op = 1'b1;
                if (n == 0) begin
                    r = a;
                end else if (n < 32) begin
                    r = $signed(a) >>> n;
                    c = a[n - 8'd1];
                end else begin
                    r = {XLEN{a[XLEN-1]}};
                    c = a[XLEN-1];
                end
            end
            OP_LSLS: begin
                shift_op = 1'b1;
                if (n == 0) begin
                    r = a;
                end else if (n < 32) begin
                    r = a << n;
                    c = a[32 - n];
                end else begin
                    r = '0;
                    c = (n == 32) ? a[0] : 1'b0;
                end
            end
            OP_LSRS: begin
                shift_op = 1'b1;
                if (n == 0) begin
                    r = a;
                end else if (n < 32) begin
                    r = a >> n;
                    c = a[n - 8'd1];
                end else begin
                    r = '0;
                    c = (n == 32) ? a[XLEN-1] : 1'b0;
                end
            end
            OP_RORS: begin
                shift_op = 1'b1;
                s        = n[4:0];
                if (n == 0) begin
                    r = a;
                end else begin
                    r = (s == 0) ? a : ((a >> s) | (a << (32 - s)));
                    c = r[XLEN-1];
                end
            end
            OP_CMP: begin
                add_with_flags(a, ~b, 1'b1, r, f);
                wr = 1'b0;
            end
            OP_CMN: begin
                add_with_flags(a, b, 1'b0, r, f);
                wr = 1'b0;
            end
            OP_MOV: begin
                r    = b;
                setf = 1'b0;
            end
            OP_MOVS: begin
                r       = b;
                nz_only = 1'b1;
            end
            OP_MVNS: begin
                r       = ~b;
                nz_only = 1'b1;
            end
            OP_MULS: begin
                r       = a * b;
                nz_only = 1'b1;
            end
            OP_REV: begin
                r    = {b[7:0], b[15:8], b[23:16], b[31:24]};
                setf = 1'b0;
            end
            OP_REV16: begin
                r    = {b[23:16], b[31:24], b[7:0], b[15:8]};
                setf = 1'b0;
            end
            OP_REVSH: begin
                r    = {{16{b[7]}}, b[7:0], b[15:8]};
                setf = 1'b0;
            end
            OP_SXTB: begin
                r    = {{24{b[7]}}, b[7:0]};
                setf = 1'b0;
            end
            OP_SXTH: begin
                r    = {{16{b[15]}}, b[15:0]};
                setf = 1'b0;
            end
            OP_UXTB: begin
                r    = {24'd0, b[7:0]};
                setf = 1'b0;
            end
            OP_UXTH: begin
                r    = {16'd0, b[15:0]};
                setf = 1'b0;
            end
            OP_TST: begin
                r       = a & b;
                nz_only = 1'b1;
                wr      = 1'b0;
            end
            OP_CPSID: begin
                arch_mask = 1'b1;
                wr        = 1'b0;
                setf      = 1'b0;
            end
            OP_CPSIE: begin
                arch_mask = 1'b0;
                wr        = 1'b0;
                setf      = 1'b0;
            end
            default: begin
                wr   = 1'b0;
                setf = 1'b0;
            end
        endcase
        // Logic ops keep C and V; shifts load C with the last bit out and keep V.
        if (nz_only) f = {nz_bits(r), arch_flags[FLAG_C], arch_flags[FLAG_V]};
        if (shift_op) f = {nz_bits(r), c, arch_flags[FLAG_V]};
        if (setf) arch_flags = f;
        if (wr) arch_regs[rd] = r;
        res.value = r;
        res.idx   = wr ? rd : '0;
        res.wr    = wr;
        res.nzcv  = arch_flags;
        res.mask  = arch_mask;
        due_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_exec_result exp_res;
        if (!i_rst_n) begin
            for (int i = 0; i < REG_CNT; i++) arch_regs[i] = '0;
            arch_flags = '0;
            arch_mask  = 1'b0;
            due_results.delete();
            fail_cnt = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("result beat with no operation outstanding");
                    fail_cnt++;
                end else begin
                    exp_res = due_results.pop_front();
                    if (i_result_value !== exp_res.value) begin
                        $error("result_value: expected %h, got %h", exp_res.value, i_result_value);
                        fail_cnt++;
                    end
                    if (i_written_index !== exp_res.idx) begin
                        $error("written_index: expected %0d, got %0d", exp_res.idx,
                               i_written_index);
                        fail_cnt++;
                    end
                    if (i_write_done !== exp_res.wr) begin
                        $error("write_done: expected %b, got %b", exp_res.wr, i_write_done);
                        fail_cnt++;
                    end
                    if (i_flags_nzcv !== exp_res.nzcv) begin
                        $error("flags_nzcv: expected %b, got %b", exp_res.nzcv, i_flags_nzcv);
                        fail_cnt++;
                    end
                    if (i_interrupts_masked !== exp_res.mask) begin
                        $error("interrupts_masked: expected %b, got %b", exp_res.mask,
                               i_interrupts_masked);
                        fail_cnt++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                execute_op(t_op'(i_mode), i_dest_index, i_first_index, i_second_index,
                           i_use_immediate, i_immediate);
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= due_results.size();
    end

endmodule

>>> sim/tb_register_alu_execute_nzcv.sv
// Testbench top for register_alu_execute_nzcv: clock, reset, operation stimulus and verdict.
module tb_register_alu_execute_nzcv;
    timeunit 1ns;
    timeprecision 1ps;
    import rae_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    t_op                in_mode;
    logic [IDX_W-1:0]   in_rd;
    logic [IDX_W-1:0]   in_rn;
    logic [IDX_W-1:0]   in_rm;
    logic               in_use_imm;
    logic [XLEN-1:0]    in_imm;
    logic               out_valid;
    logic               out_stall;
    logic [XLEN-1:0]    out_value;
    logic [IDX_W-1:0]   out_index;
    logic               out_write;
    logic [FLAG_W-1:0]  out_flags;
    logic               out_mask;
    int                 fail_count;
    int                 pending;
    int                 quiet_cycles;
    bit                 idle_on;
    bit                 long_hold_ask;
    bit                 long_hold_taken;

    register_alu_execute_nzcv dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_mode              (in_mode),
        .i_dest_index        (in_rd),
        .i_first_index       (in_rn),
        .i_second_index      (in_rm),
        .i_use_immediate     (in_use_imm),
        .i_immediate         (in_imm),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_result_value      (out_value),
        .o_written_index     (out_index),
        .o_write_done        (out_write),
        .o_flags_nzcv        (out_flags),
        .o_interrupts_masked (out_mask)
    );

    register_alu_execute_nzcv_checker u_result_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_mode              (in_mode),
        .i_dest_index        (in_rd),
        .i_first_index       (in_rn),
        .i_second_index      (in_rm),
        .i_use_immediate     (in_use_imm),
        .i_immediate         (in_imm),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_result_value      (out_value),
        .i_written_index     (out_index),
        .i_write_done        (out_write),
        .i_flags_nzcv        (out_flags),
        .i_interrupts_masked (out_mask),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Offer one operation beat and hold it until the block takes it.
    task automatic send_beat(input t_op op, input logic [IDX_W-1:0] rd,
                             input logic [IDX_W-1:0] rn, input logic [IDX_W-1:0] rm,
                             input logic use_imm, input logic [XLEN-1:0] imm);
        int gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_mode    <= op;
        in_rd      <= rd;
        in_rn      <= rn;
        in_rm      <= rm;
        in_use_imm <= use_imm;
        in_imm     <= imm;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_random_beat();
        t_op             op;
        logic [XLEN-1:0] imm;
        op = t_op'($urandom_range(0, 31));
        case ($urandom_range(0, 7))
            0:       imm = '0;
            1:       imm = 32'hFFFF_FFFF;
            2:       imm = 32'h8000_0000;
            3:       imm = 32'h7FFF_FFFF;
            4:       imm = $urandom_range(0, 40);
            5:       imm = 32'd1;
            default: imm = $urandom;
        endcase
        // Keep most shift amounts near the word boundary.
        if (op inside {OP_ASRS, OP_LSLS, OP_LSRS, OP_RORS} && $urandom_range(0, 2) != 0)
            imm = {$urandom} & 32'hFFFF_FF00 | $urandom_range(0, 66);
        send_beat(op, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                  IDX_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), imm);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Receiver: random stalls before result beats, none in the burst but one long hold.
    initial begin
        int hold;
        out_stall <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (long_hold_ask && !long_hold_taken) begin
                long_hold_taken = 1'b1;
                hold = LONG_HOLD;
            end else begin
                hold = idle_on ? $urandom_range(0, 13) : 0;
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_register_alu_execute_nzcv NOT OK");
            $finish;
        end
    end

    initial begin
        idle_on         = 1'b1;
        long_hold_ask   = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_mode    <= OP_NOP;
        in_rd      <= '0;
        in_rn      <= '0;
        in_rm      <= '0;
        in_use_imm <= 1'b0;
        in_imm     <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load extreme values, then hit every operation and the shift corner cases.
        send_beat(OP_MOVS,  4'd0,  4'd0,  4'd0,  1'b1, 32'hFFFF_FFFF);
        send_beat(OP_MOV,   4'd1,  4'd0,  4'd0,  1'b1, 32'h8000_0000);
        send_beat(OP_MOV,   4'd2,  4'd0,  4'd0,  1'b1, 32'h7FFF_FFFF);
        send_beat(OP_MOVS,  4'd3,  4'd0,  4'd0,  1'b1, 32'h0000_0000);
        send_beat(OP_ADDS,  4'd4,  4'd1,  4'd1,  1'b0, 32'h0);
        send_beat(OP_ADCS,  4'd5,  4'd2,  4'd3,  1'b0, 32'h0);
        send_beat(OP_SUBS,  4'd6,  4'd3,  4'd1,  1'b0, 32'h0);
        send_beat(OP_SBCS,  4'd7,  4'd0,  4'd2,  1'b0, 32'h0);
        send_beat(OP_RSBS,  4'd8,  4'd1,  4'd0,  1'b0, 32'h0);
        send_beat(OP_SUB,   4'd9,  4'd3,  4'd0,  1'b0, 32'h0);
        send_beat(OP_ADD,   4'd10, 4'd0,  4'd0,  1'b0, 32'h0);
        send_beat(OP_CMP,   4'd11, 4'd2,  4'd1,  1'b0, 32'h0);
        send_beat(OP_CMN,   4'd11, 4'd0,  4'd0,  1'b1, 32'h1);
        send_beat(OP_TST,   4'd11, 4'd1,  4'd2,  1'b0, 32'h0);
        send_beat(OP_ANDS,  4'd11, 4'd0,  4'd0,  1'b1, 32'hF0F0_F0F0);
        send_beat(OP_ORRS,  4'd12, 4'd3,  4'd1,  1'b0, 32'h0);
        send_beat(OP_EORS,  4'd13, 4'd0,  4'd2,  1'b0, 32'h0);
        send_beat(OP_BICS,  4'd14, 4'd0,  4'd2,  1'b0, 32'h0);
        send_beat(OP_LSLS,  4'd4,  4'd0,  4'd0,  1'b1, 32'h0000_0100);
        send_beat(OP_LSLS,  4'd4,  4'd2,  4'd0,  1'b1, 32'd32);
        send_beat(OP_LSLS,  4'd4,  4'd0,  4'd0,  1'b1, 32'd33);
        send_beat(OP_LSRS,  4'd4,  4'd1,  4'd0,  1'b1, 32'd32);
        send_beat(OP_LSRS,  4'd4,  4'd0,  4'd0,  1'b1, 32'd40);
        send_beat(OP_ASRS,  4'd4,  4'd1,  4'd0,  1'b1, 32'd40);
        send_beat(OP_ASRS,  4'd4,  4'd1,  4'd0,  1'b1, 32'd31);
        send_beat(OP_RORS,  4'd4,  4'd1,  4'd0,  1'b1, 32'd64);
        send_beat(OP_RORS,  4'd4,  4'd2,  4'd3,  1'b0, 32'h0);
        send_beat(OP_MVNS,  4'd5,  4'd0,  4'd3,  1'b0, 32'h0);
        send_beat(OP_MULS,  4'd6,  4'd0,  4'd0,  1'b0, 32'h0);
        send_beat(OP_REV,   4'd7,  4'd0,  4'd0,  1'b1, 32'h1234_5680);
        send_beat(OP_REV16, 4'd7,  4'd0,  4'd0,  1'b1, 32'h1234_5680);
        send_beat(OP_REVSH, 4'd7,  4'd0,  4'd0,  1'b1, 32'h1234_5680);
        send_beat(OP_SXTB,  4'd8,  4'd0,  4'd0,  1'b1, 32'h0000_0080);
        send_beat(OP_SXTH,  4'd8,  4'd0,  4'd0,  1'b1, 32'h0000_8000);
        send_beat(OP_UXTB,  4'd8,  4'd0,  4'd0,  1'b1, 32'hFFFF_FFFF);
        send_beat(OP_UXTH,  4'd8,  4'd0,  4'd0,  1'b1, 32'hFFFF_FFFF);
        send_beat(OP_CPSID, 4'd9,  4'd0,  4'd0,  1'b0, 32'h0);
        send_beat(OP_NOP,   4'd9,  4'd0,  4'd0,  1'b0, 32'h0);
        send_beat(OP_CPSIE, 4'd9,  4'd0,  4'd0,  1'b0, 32'h0);
        send_beat(OP_MOV,   4'd15, 4'd0,  4'd0,  1'b1, 32'hDEAD_BEEF);

        repeat (500) send_random_beat();

        // Back-to-back burst against a long receiver hold-off: fill the pipe.
        idle_on       = 1'b0;
        long_hold_ask = 1'b1;
        repeat (200) send_random_beat();
        idle_on = 1'b1;

        wait_drained();
        repeat (600) send_random_beat();

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_register_alu_execute_nzcv OK");
        else
            $display("tb_register_alu_execute_nzcv NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rae_pkg.sv
rtl/core/rae_regfile.sv
rtl/core/rae_alu.sv
rtl/core/register_alu_execute_nzcv.sv
rtl/core/rae_checker.sv
sim/register_alu_execute_nzcv_checker.sv
sim/tb_register_alu_execute_nzcv.sv
